/* rtl/core/csfp_pkg.sv */
// Package: shared constants, opcodes and types of the segment fixup patcher.
`default_nettype none
package csfp_pkg;
  localparam int LOOKAHEAD  = 32;
  localparam int FILL_W     = $clog2(LOOKAHEAD + 1);
  localparam int IDX_W      = $clog2(LOOKAHEAD);
  localparam int POS_W      = 17;
  localparam int CNT_W      = 16;
  localparam int OFS_W      = 16;
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] OP_PUSH_CS = 8'h0e;
  localparam logic [7:0] OP_POP_DS  = 8'h1f;
  localparam logic [7:0] OP_NOP     = 8'h90;
  localparam logic [7:0] OP_POP_ES  = 8'h07;
  localparam logic [7:0] OP_PUSH_DS = 8'h1e;
  localparam logic [7:0] OP_CS_PFX  = 8'h2e;
  localparam logic [7:0] OP_DS_PFX  = 8'h3e;
  localparam logic [7:0] OP_MOV_RS  = 8'h8c;
  localparam logic [7:0] OP_MOV_SR  = 8'h8e;
  localparam logic [7:0] MODRM_MASK = 8'hf8;
  localparam logic [7:0] MODRM_CS   = 8'hc8;
  localparam logic [7:0] MODRM_DS   = 8'hd8;
  localparam logic [7:0] OP_XOR_A   = 8'h31;
  localparam logic [7:0] OP_XOR_B   = 8'h33;
  localparam logic [7:0] MODRM_AXAX = 8'hc0;
  localparam logic [7:0] OP_PUSH_AX = 8'h50;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } csfp_item_t;

  typedef struct packed {
    logic       valid;
    csfp_item_t item;
  } csfp_qhead_t;

  function automatic logic is_data_op(logic [7:0] op);
    return op == 8'h89 || op == 8'h8b || op == 8'h8e || op == 8'ha1 ||
           op == 8'ha3 || op == 8'hc7 || op == 8'hff;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/csfp_in_if.sv */
// Interface: input byte request channel.
`default_nettype none
interface csfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

/* rtl/core/csfp_out_if.sv */
// Interface: patched byte request channel.
`default_nettype none
interface csfp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [15:0] patch_count;
  modport source (output valid, output out_byte, output out_last, output patch_count,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input patch_count,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/csfp_front.sv */
// Front: accepts input requests into a short queue for the back end.
`default_nettype none
module csfp_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  csfp_in_if.sink                   in_i,
  output csfp_pkg::csfp_qhead_t     head_o,
  input  wire logic                 pop_i
);
  import csfp_pkg::*;

  csfp_item_t          mem_q [FIFO_DEPTH];
  logic [FPTR_W-1:0]   wp_q, rp_q;
  logic [FCNT_W-1:0]   cnt_q;
  logic                push, pop;

  assign in_i.ready  = cnt_q < FCNT_W'(FIFO_DEPTH);
  assign push        = in_i.valid && in_i.ready;
  assign pop         = pop_i && (cnt_q != '0);
  assign head_o.valid = cnt_q != '0;
  assign head_o.item  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{data: in_i.in_byte, last: in_i.in_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + FCNT_W'(push) - FCNT_W'(pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/core/csfp_back.sv */
// Back: look-ahead window, patch rules and output register.
`default_nettype none
module csfp_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [csfp_pkg::OFS_W-1:0] start_offset_i,
  input  csfp_pkg::csfp_qhead_t         head_i,
  output logic                          pop_o,
  csfp_out_if.source                    out_o
);
  import csfp_pkg::*;

  logic [7:0]        win_q [LOOKAHEAD];
  logic [FILL_W-1:0] fill_q;
  logic [1:0]        skip_q;
  logic [POS_W-1:0]  pos_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              last_q;
  logic              ovalid_q, olast_q;
  logic [7:0]        obyte_q;
  logic [CNT_W-1:0]  ocnt_q;

  logic       untested, emit_req, emit, final_b, apply, found, hit, set_skip;
  logic [7:0] b0, b1, want, new_b0, new_b1;

  always_comb begin
    b0       = win_q[0];
    b1       = win_q[1];
    want     = MODRM_DS | (b1 & 8'h07);
    untested = (skip_q != 2'd0) || (pos_q < POS_W'(start_offset_i));
    emit_req = (fill_q != '0) &&
               (untested || fill_q == FILL_W'(LOOKAHEAD) || last_q);
    emit     = emit_req && (!ovalid_q || out_o.ready);
    pop_o    = !emit_req && !last_q && head_i.valid;
    final_b  = last_q && fill_q == FILL_W'(1);
    apply    = !untested && fill_q >= FILL_W'(2);
    found    = 1'b0;
    for (int k = 2; k < LOOKAHEAD - 1; k++) begin
      found |= (FILL_W'(k + 1) < fill_q) && win_q[k] == OP_MOV_SR && win_q[k+1] == want;
    end
    new_b0   = b0;
    new_b1   = b1;
    hit      = 1'b0;
    set_skip = 1'b0;
    if (apply) begin
      if (b0 == OP_PUSH_CS && b1 == OP_POP_DS) begin
        new_b0 = OP_NOP; new_b1 = OP_NOP; hit = 1'b1;
      end else if (b0 == OP_PUSH_CS && b1 == OP_POP_ES) begin
        new_b0 = OP_PUSH_DS; hit = 1'b1;
      end else if (b0 == OP_CS_PFX && is_data_op(b1)) begin
        new_b0 = OP_DS_PFX; hit = 1'b1;
      end else if (b0 == OP_MOV_RS && (b1 & MODRM_MASK) == MODRM_CS) begin
        if (found) begin
          new_b1 = want; hit = 1'b1;
        end
      end else if (b0 == OP_PUSH_DS && fill_q >= FILL_W'(4) &&
                   (b1 == OP_XOR_A || b1 == OP_XOR_B) &&
                   win_q[2] == MODRM_AXAX && win_q[3] == OP_PUSH_AX) begin
        new_b0 = OP_PUSH_CS; hit = 1'b1; set_skip = 1'b1;
      end
    end
  end

  // window payload: shift on emit, append on pop
  always_ff @(posedge clk_i) begin
    if (emit) begin
      win_q[0] <= new_b1;
      for (int i = 1; i < LOOKAHEAD - 1; i++) win_q[i] <= win_q[i+1];
      win_q[LOOKAHEAD-1] <= 8'h00;
    end else if (pop_o) begin
      win_q[fill_q[IDX_W-1:0]] <= head_i.item.data;
    end
    if (emit) begin
      obyte_q <= new_b0;
      olast_q <= final_b;
      ocnt_q  <= final_b ? cnt_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      skip_q   <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      last_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      if (emit) begin
        fill_q <= fill_q - 1'b1;
        if (final_b) begin
          pos_q  <= '0;
          skip_q <= '0;
          cnt_q  <= '0;
          last_q <= 1'b0;
        end else begin
          if (pos_q != '1) pos_q <= pos_q + 1'b1;
          if (set_skip) skip_q <= 2'd3;
          else if (skip_q != 2'd0) skip_q <= skip_q - 1'b1;
          if (hit && cnt_q != '1) cnt_q <= cnt_q + 1'b1;
        end
      end else if (pop_o) begin
        fill_q <= fill_q + 1'b1;
        last_q <= head_i.item.last;
      end
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.out_byte    = obyte_q;
  assign out_o.out_last    = olast_q;
  assign out_o.patch_count = ocnt_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(LOOKAHEAD)) else $error("window overfill");
  a_no_pop_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit && pop_o)) else $error("pop and emit together");
  a_final_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && final_b) |=> (pos_q == '0 && cnt_q == '0 && !last_q && fill_q == '0))
    else $error("image state not cleared after final byte");
  a_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> !emit) else $error("emit from empty window");
endmodule
`default_nettype wire

/* rtl/core/com_segment_fixup_patcher.sv */
// Top level: segment fixup patcher with config register, front queue and back end.
// Flow: untested bytes pass the queue, window and output register; a tested byte waits
//   until 32 bytes from it are held in the window or the final byte has arrived.
// Throughput: the back end either appends or emits one byte per cycle while the output
//   is not held by ready; the final flush drains one byte per cycle, also unless held.
// Reset: asynchronous active low; clears queue, window count, scan position,
//   skip and patch count, and sets start_offset to 256.
`default_nettype none
module com_segment_fixup_patcher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  csfp_in_if.sink          in_i,
  csfp_out_if.source       out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);
  import csfp_pkg::*;

  // start_offset register; the user writes it only while idle, the block does not enforce it
  logic [OFS_W-1:0] start_offset_q;
  csfp_qhead_t      head;   // queue head toward back end
  logic             pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_offset_q <= OFS_W'(256);
    end else if (cfg_we_i) begin
      start_offset_q <= cfg_wdata_i;
    end
  end

  // front: takes requests, buffers them
  csfp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  // back: window, rule match, output register
  csfp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_offset_i (start_offset_q),
    .head_i         (head),
    .pop_o          (pop),
    .out_o          (out_o)
  );
endmodule
`default_nettype wire

/* tb/com_segment_fixup_patcher_test.sv */
// Testbench: segment fixup patcher checked against its own byte-window predictor.
`timescale 1ns / 100ps
module com_segment_fixup_patcher_test;
  import csfp_pkg::*;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic [15:0] count;
  } patched_byte_t;

  // Patch predictor: mirrors the window, scan position, skip and patch count
  // of the block and queues the patched bytes it should emit.
  class patch_scoreboard;
    logic [7:0]    win [LOOKAHEAD];
    int            fill;
    int            skip;
    logic [16:0]   pos;
    logic [15:0]   patches;
    logic [15:0]   offset;
    patched_byte_t pending [$];
    int            errors;
    int            bytes_out;
    int            images;
    int            patches_seen;

    function new();
      foreach (win[i]) win[i] = '0;
      fill = 0; skip = 0; pos = '0; patches = '0; offset = 16'd256;
      errors = 0; bytes_out = 0; images = 0; patches_seen = 0;
    endfunction

    function void bump();
      if (patches != 16'hffff) patches++;
    endfunction

    // Apply the first matching rule at the oldest window byte.
    function void patch_head();
      logic [7:0] want;
      if (win[0] == OP_PUSH_CS && win[1] == OP_POP_DS) begin
        win[0] = OP_NOP; win[1] = OP_NOP; bump();
      end else if (win[0] == OP_PUSH_CS && win[1] == OP_POP_ES) begin
        win[0] = OP_PUSH_DS; bump();
      end else if (win[0] == OP_CS_PFX &&
                   (win[1] == 8'h89 || win[1] == 8'h8b || win[1] == 8'h8e ||
                    win[1] == 8'ha1 || win[1] == 8'ha3 || win[1] == 8'hc7 ||
                    win[1] == 8'hff)) begin
        win[0] = OP_DS_PFX; bump();
      end else if (win[0] == OP_MOV_RS && (win[1] & MODRM_MASK) == MODRM_CS) begin
        want = MODRM_DS | (win[1] & 8'h07);
        for (int k = 2; k + 1 < fill && k + 1 < LOOKAHEAD; k++) begin
          if (win[k] == OP_MOV_SR && win[k+1] == want) begin
            win[1] = want; bump();
            break;
          end
        end
      end else if (win[0] == OP_PUSH_DS && fill >= 4 &&
                   (win[1] == OP_XOR_A || win[1] == OP_XOR_B) &&
                   win[2] == MODRM_AXAX && win[3] == OP_PUSH_AX) begin
        win[0] = OP_PUSH_CS; bump();
        skip = 3;
      end
    endfunction

    // An input byte was accepted: work out every byte it releases.
    function void note_request(logic [7:0] b, logic l);
      patched_byte_t e;
      if (fill < LOOKAHEAD) begin
        win[fill] = b; fill++;
      end
      while (fill > 0) begin
        if (skip > 0) skip--;
        else if (pos < {1'b0, offset}) ;
        else if (fill >= LOOKAHEAD || l) begin
          if (fill >= 2) patch_head();
        end else break;
        e.data  = win[0];
        e.last  = l && fill == 1;
        e.count = e.last ? patches : 16'd0;
        pending.push_back(e);
        for (int i = 0; i < LOOKAHEAD - 1; i++) win[i] = win[i+1];
        win[LOOKAHEAD-1] = '0;
        fill--;
        if (pos != 17'h1ffff) pos++;
      end
      if (l) begin
        pos = '0; skip = 0; patches = '0;
      end
    endfunction

    function void check_result(logic [7:0] d, logic l, logic [15:0] c);
      patched_byte_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected byte %h last %b count %0d", $time, d, l, c);
        errors++;
        return;
      end
      e = pending.pop_front();
      bytes_out++;
      if (l) begin
        images++; patches_seen += c;
      end
      if (d !== e.data || l !== e.last || c !== e.count) begin
        $display("%0t: mismatch exp byte %h last %b count %0d, got %h %b %0d",
                 $time, e.data, e.last, e.count, d, l, c);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          hold_cycles;
  patch_scoreboard sb;

  csfp_in_if  in_if ();
  csfp_out_if out_if ();

  com_segment_fixup_patcher i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Monitor: note accepted requests first, then check emitted bytes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_request(in_if.in_byte, in_if.in_last);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.out_byte, out_if.out_last, out_if.patch_count);
    end
  end

  // Receiver: random stalls, or a counted long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // One byte request; valid stays high into the next call when there is no gap.
  task automatic send_byte(logic [7:0] b, logic l);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= l;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic send_image(logic [7:0] img [$]);
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
  endtask

  // Sender pauses until every expected byte is back, then lets the block settle.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_offset(logic [15:0] v);
    drain();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    sb.offset = v;
  endtask

  // Random image seeded with rule patterns; a few are mangled on purpose.
  task automatic rand_image(int max_len, output logic [7:0] img [$]);
    int len;
    logic [7:0] r;
    img = {};
    len = $urandom_range(max_len, 1);
    while (img.size() < len) begin
      r = 8'($urandom_range(7));
      case ($urandom_range(7))
        0: img.push_back(8'($urandom_range(255)));
        1: img = {img, OP_PUSH_CS, ($urandom_range(1) ? OP_POP_DS : OP_POP_ES)};
        2: img = {img, OP_CS_PFX, ($urandom_range(3) == 0 ? 8'($urandom_range(255)) :
                  ($urandom_range(1) ? 8'hff : 8'h89))};
        3: begin
          img = {img, OP_MOV_RS, MODRM_CS | r};
          repeat ($urandom_range(8)) img.push_back(8'($urandom_range(255)));
          img = {img, OP_MOV_SR, ($urandom_range(4) == 0 ? MODRM_DS : (MODRM_DS | r))};
        end
        4: img = {img, OP_PUSH_DS, ($urandom_range(1) ? OP_XOR_A : OP_XOR_B),
                  ($urandom_range(5) == 0 ? 8'h00 : MODRM_AXAX), OP_PUSH_AX};
        default: img.push_back(8'($urandom_range(255)));
      endcase
    end
  endtask

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [7:0] img [$];
    sb = new();
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    in_if.in_last = 1'b0;
    out_if.ready = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_cycles = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset offset: a short image passes unchanged.
    send_image('{OP_PUSH_CS, OP_POP_DS});

    // Directed: every rule at offset 0, short ends, one-byte images.
    set_offset(16'd0);
    send_image('{OP_PUSH_CS, OP_POP_DS, 8'h00});
    send_image('{OP_PUSH_CS, OP_POP_ES, OP_CS_PFX, 8'ha1, 8'hff});
    send_image('{OP_MOV_RS, 8'hcb, 8'h11, OP_MOV_SR, 8'hdb, OP_MOV_RS, 8'hc8, 8'h22});
    send_image('{OP_PUSH_DS, OP_XOR_B, MODRM_AXAX, OP_PUSH_AX, OP_PUSH_CS, OP_POP_DS});
    send_image('{OP_PUSH_DS, OP_XOR_A, MODRM_AXAX});
    send_image('{8'h00});
    send_image('{8'hff});

    // Largest offset: nothing is tested.
    set_offset(16'hffff);
    send_image('{OP_PUSH_CS, OP_POP_DS, OP_CS_PFX, 8'h8b});

    // Random images with a small offset, through each idling mode.
    for (int ph = 0; ph < 4; ph++) begin
      set_offset(ph == 0 ? 16'd0 : 16'($urandom_range(6)));
      tx_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 58 : 22) : 0;
      rx_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 58 : 22) : 0;
      repeat (2) begin
        rand_image(8, img);
        send_image(img);
      end
    end

    // Long receiver hold-off while the sender keeps going: input must stall.
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    set_offset(16'd2);
    @(negedge clk_i);
    hold_cycles = 200;
    img = {OP_PUSH_CS, OP_POP_ES};
    repeat (38) img.push_back(8'($urandom_range(255)));
    send_image(img);

    drain();
    $display("Checked %0d patched bytes in %0d images, %0d patches reported.",
             sb.bytes_out, sb.images, sb.patches_seen);
    $display("Covered every rule, offsets 0 to 65535, four idling modes and a long stall.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
